>>> hdl/wgm_pkg.sv
// Shared types, character constants and helpers for the wildcard glob matcher.
// Used by wgm_cell and wildcard_glob_matcher_core; depends on nothing else.
`timescale 1ns / 1ps

package wgm_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_APPEND  = 2'd1,
		OP_SUBJECT = 2'd2,
		OP_END     = 2'd3
	} op_t;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_ANY   = 8'h3F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	// Broadcast from the top level to every cell in the chain.
	typedef struct packed {
		logic       take;
		op_t        op;
		logic [7:0] char_code;
		logic [7:0] char_lc;
	} ctl_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			r = c + CASE_GAP;
		end
		return r;
	endfunction

endpackage

>>> hdl/wgm_cell.sv
// One pattern cell: a stored pattern byte, its in-use bit and the NFA bit of
// the position after it. Depends on wgm_pkg.
`timescale 1ns / 1ps

module wgm_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  wgm_pkg::ctl_t ctl,
	input  logic          prev_used,
	input  logic          next_used,
	input  logic          closed_in,
	input  logic          stay_in,
	output logic          closed_out,
	output logic          stay_out,
	output logic          used,
	output logic          hit,
	output logic [7:0]    pat_byte
);

	logic [7:0] byte_q;
	logic       used_q;
	logic       act_q;
	logic       is_star;
	logic       is_any;
	logic       is_eq;
	logic       live;
	logic       adv;
	logic       wr_en;

	assign is_star = (byte_q == wgm_pkg::CH_STAR);
	assign is_any  = (byte_q == wgm_pkg::CH_ANY);
	assign is_eq   = (wgm_pkg::fold_case(byte_q) == ctl.char_lc);

	// closed_in is the star-closed state of the position this byte starts from
	assign live       = closed_in & used_q;
	assign stay_out   = live & is_star;
	assign adv        = live & ~is_star & (is_any | is_eq);
	assign closed_out = act_q | stay_out;
	assign hit        = closed_out & used_q & ~next_used;

	assign used     = used_q;
	assign pat_byte = byte_q;

	// first free cell takes the appended byte
	assign wr_en = ctl.take && (ctl.op == wgm_pkg::OP_APPEND) && prev_used && !used_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			byte_q <= ctl.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			act_q  <= 1'b0;
		end else if (ctl.take) begin
			case (ctl.op)
				wgm_pkg::OP_CLEAR: begin
					used_q <= 1'b0;
					act_q  <= 1'b0;
				end
				wgm_pkg::OP_APPEND: begin
					if (wr_en) begin
						used_q <= 1'b1;
					end
					act_q <= 1'b0;
				end
				wgm_pkg::OP_SUBJECT: begin
					act_q <= adv | stay_in;
				end
				wgm_pkg::OP_END: begin
					act_q <= 1'b0;
				end
				default: begin
					act_q <= act_q;
				end
			endcase
		end
	end

endmodule

>>> hdl/wildcard_glob_matcher_core.sv
// Top level of the wildcard glob matcher: control, chain of wgm_cell
// instances, verdict logic and result register. Depends on wgm_pkg, wgm_cell.
`timescale 1ns / 1ps

// Usage
//   Item channel (item_valid/item_stall, op, char_code): op selects clear
//   pattern, append pattern byte, subject byte or end of subject. Every op
//   but end of subject is always taken and never stalls.
//   Result channel (result_valid/result_stall, matched, pattern_overflow):
//   one transaction per end-of-subject item, valid the cycle after that item
//   is accepted.
//   Throughput is one item per cycle while item_stall is low. Each subject
//   byte updates all PATTERN_MAX cells at once; the star closure ripples
//   through the chain of cells within that cycle.
//   While a result waits under result_stall, the block keeps taking items;
//   only a further end-of-subject item is held off with item_stall until the
//   result register drains.
//   After reset the pattern is empty (matches everything), no overflow is
//   flagged and the result register is empty. Appends beyond PATTERN_MAX
//   bytes are dropped and flagged until the next clear.
module wildcard_glob_matcher_core #(
	parameter int PATTERN_MAX = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] op,
	input  logic [7:0] char_code,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       matched,
	output logic       pattern_overflow
);

	wgm_pkg::ctl_t            ctl;
	wgm_pkg::op_t             op_c;
	logic                     take;
	logic [PATTERN_MAX-1:0]   used_v;
	logic [PATTERN_MAX+1:0]   used_ext;
	logic [PATTERN_MAX:0]     closed_v;
	logic [PATTERN_MAX:0]     stay_v;
	logic [PATTERN_MAX-1:0]   hit_v;
	logic [7:0]               byte_v [PATTERN_MAX];
	logic                     pos0_q;
	logic                     ovf_q;
	logic                     res_valid_q;
	logic                     matched_q;
	logic                     res_ovf_q;
	logic                     all_match;
	logic                     hit;

	assign op_c       = wgm_pkg::op_t'(op);
	assign item_stall = res_valid_q & result_stall & (op_c == wgm_pkg::OP_END);
	assign take       = item_valid & ~item_stall;

	assign ctl.take      = take;
	assign ctl.op        = op_c;
	assign ctl.char_code = char_code;
	assign ctl.char_lc   = wgm_pkg::fold_case(char_code);

	// padded in-use vector: a used cell before cell 0, an empty one after the last
	assign used_ext    = {1'b0, used_v, 1'b1};
	assign closed_v[0] = pos0_q;
	assign stay_v[PATTERN_MAX] = 1'b0;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		wgm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_used  (used_ext[i]),
			.next_used  (used_ext[i+2]),
			.closed_in  (closed_v[i]),
			.stay_in    (stay_v[i+1]),
			.closed_out (closed_v[i+1]),
			.stay_out   (stay_v[i]),
			.used       (used_v[i]),
			.hit        (hit_v[i]),
			.pat_byte   (byte_v[i])
		);
	end

	// empty pattern, or exactly "*.*"
	assign all_match = ~used_v[0] |
		(used_v[2] & ~used_ext[4] &
		 (byte_v[0] == wgm_pkg::CH_STAR) &
		 (byte_v[1] == wgm_pkg::CH_DOT) &
		 (byte_v[2] == wgm_pkg::CH_STAR));
	assign hit = all_match | (|hit_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos0_q <= 1'b1;
			ovf_q  <= 1'b0;
		end else if (take) begin
			case (op_c)
				wgm_pkg::OP_CLEAR: begin
					pos0_q <= 1'b1;
					ovf_q  <= 1'b0;
				end
				wgm_pkg::OP_APPEND: begin
					pos0_q <= 1'b1;
					if (used_v[PATTERN_MAX-1]) begin
						ovf_q <= 1'b1;
					end
				end
				wgm_pkg::OP_SUBJECT: begin
					pos0_q <= stay_v[0];
				end
				wgm_pkg::OP_END: begin
					pos0_q <= 1'b1;
				end
				default: begin
					pos0_q <= pos0_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && op_c == wgm_pkg::OP_END) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && op_c == wgm_pkg::OP_END) begin
			matched_q <= hit;
			res_ovf_q <= ovf_q;
		end
	end

	assign result_valid     = res_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = res_ovf_q;

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("item stalled with empty result register");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && op_c == wgm_pkg::OP_END) |=> result_valid)
		else $error("end of subject accepted but no result transaction");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(take && op_c == wgm_pkg::OP_CLEAR) |=> (!used_v[0] && !ovf_q && pos0_q))
		else $error("clear did not empty the pattern");

	a_used_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((used_v & (used_v + PATTERN_MAX'(1))) == '0))
		else $error("pattern cells in use are not contiguous from cell 0");
`endif

endmodule

>>> test/tb_wildcard_glob_matcher_core.sv
// Self-checking testbench for wildcard_glob_matcher_core: pattern loads, subject
// streams and end-of-subject verdicts checked against an in-bench NFA predictor.
// Depends on wgm_pkg and the wildcard_glob_matcher_core RTL.
`timescale 1ns / 1ps

module tb_wildcard_glob_matcher_core;

	localparam int PMAX       = 32;
	localparam int ITEM_GOAL  = 1350;
	localparam int CYCLE_CAP  = 400000;

	typedef struct {
		wgm_pkg::op_t opc;
		logic [7:0]   ch;
		bit           drain;  // pause marker: hold off until every verdict is back
	} glob_item_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic [1:0] op = wgm_pkg::OP_CLEAR;
	logic [7:0] char_code = 8'h00;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic       matched;
	logic       pattern_overflow;

	glob_item_t glob_items[$];
	verdict_t   verdicts_due[$];
	logic [7:0] gen_pat[$];
	int         errors = 0;
	int         cycles = 0;
	int         item_count = 0;

	// predictor state
	logic [7:0]    pat_mem [PMAX];
	int            pat_len = 0;
	logic [PMAX:0] live = (PMAX+1)'(1);
	logic          ovf_flag = 1'b0;

	wildcard_glob_matcher_core #(
		.PATTERN_MAX(PMAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.op(op),
		.char_code(char_code),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.matched(matched),
		.pattern_overflow(pattern_overflow)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] lower_byte(input logic [7:0] b);
		if (b >= wgm_pkg::CH_UP_A && b <= wgm_pkg::CH_UP_Z) begin
			return b + wgm_pkg::CASE_GAP;
		end
		return b;
	endfunction

	// stars at live positions also light the next position; ripples in order
	task automatic star_closure();
		for (int i = 0; i < pat_len; i++) begin
			if (live[i] && pat_mem[i] == wgm_pkg::CH_STAR) begin
				live[i+1] = 1'b1;
			end
		end
	endtask

	task automatic glob_predict(input wgm_pkg::op_t o, input logic [7:0] c);
		logic [PMAX:0] nxt;
		logic          hit;
		case (o)
			wgm_pkg::OP_CLEAR: begin
				pat_len = 0;
				ovf_flag = 1'b0;
				live = (PMAX+1)'(1);
			end
			wgm_pkg::OP_APPEND: begin
				if (pat_len < PMAX) begin
					pat_mem[pat_len] = c;
					pat_len++;
				end else begin
					ovf_flag = 1'b1;
				end
				live = (PMAX+1)'(1);
			end
			wgm_pkg::OP_SUBJECT: begin
				star_closure();
				nxt = '0;
				for (int i = 0; i < pat_len; i++) begin
					if (live[i]) begin
						if (pat_mem[i] == wgm_pkg::CH_STAR) begin
							nxt[i] = 1'b1;
						end else if (pat_mem[i] == wgm_pkg::CH_ANY ||
								lower_byte(pat_mem[i]) == lower_byte(c)) begin
							nxt[i+1] = 1'b1;
						end
					end
				end
				live = nxt;
			end
			default: begin
				star_closure();
				hit = (pat_len == 0) || live[pat_len];
				if (pat_len == 3 && pat_mem[0] == wgm_pkg::CH_STAR &&
						pat_mem[1] == wgm_pkg::CH_DOT &&
						pat_mem[2] == wgm_pkg::CH_STAR) begin
					hit = 1'b1;
				end
				verdicts_due.push_back('{matched: hit, overflow: ovf_flag});
				live = (PMAX+1)'(1);
			end
		endcase
	endtask

	task automatic add_item(input wgm_pkg::op_t o, input logic [7:0] c);
		glob_items.push_back('{opc: o, ch: c, drain: 1'b0});
		item_count++;
	endtask

	task automatic add_drain();
		glob_items.push_back('{opc: wgm_pkg::OP_CLEAR, ch: 8'h00, drain: 1'b1});
	endtask

	function automatic logic [7:0] pool_byte();
		case ($urandom_range(0, 11))
			0: return "a";
			1: return "b";
			2: return "c";
			3: return "A";
			4: return "B";
			5: return "C";
			6: return "Z";
			7: return "z";
			8: return "@";
			9: return "[";
			10: return 8'h60;
			default: return "{";
		endcase
	endfunction

	function automatic logic [7:0] pick_pat_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return wgm_pkg::CH_STAR;
		if (r < 32) return wgm_pkg::CH_ANY;
		if (r < 36) return wgm_pkg::CH_DOT;
		if (r < 44) return 8'($urandom_range(0, 255));
		return pool_byte();
	endfunction

	function automatic logic [7:0] subj_byte();
		if ($urandom_range(0, 9) < 7) return pool_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] flip_case(input logic [7:0] b);
		logic [7:0] up;
		up = b & ~wgm_pkg::CASE_GAP;
		if (up >= wgm_pkg::CH_UP_A && up <= wgm_pkg::CH_UP_Z && $urandom_range(0, 1)) begin
			return b ^ wgm_pkg::CASE_GAP;
		end
		return b;
	endfunction

	// subject built to follow the pattern, with occasional damage
	task automatic add_subject();
		logic [7:0] b;
		foreach (gen_pat[k]) begin
			if ($urandom_range(0, 24) == 0) begin
				add_item(wgm_pkg::OP_SUBJECT, subj_byte());
			end
			if ($urandom_range(0, 24) != 0) begin
				b = gen_pat[k];
				if (b == wgm_pkg::CH_STAR) begin
					repeat ($urandom_range(0, 3)) add_item(wgm_pkg::OP_SUBJECT, subj_byte());
				end else if (b == wgm_pkg::CH_ANY) begin
					add_item(wgm_pkg::OP_SUBJECT, subj_byte());
				end else begin
					add_item(wgm_pkg::OP_SUBJECT, flip_case(b));
				end
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			add_item(wgm_pkg::OP_SUBJECT, subj_byte());
		end
		add_item(wgm_pkg::OP_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic build_stimulus();
		int         r;
		int         len;
		logic [7:0] b;
		// directed
		add_item(wgm_pkg::OP_END, 8'h00);              // empty pattern, empty subject
		add_item(wgm_pkg::OP_SUBJECT, 8'h00);          // zero byte is ordinary
		add_item(wgm_pkg::OP_SUBJECT, 8'hFF);
		add_item(wgm_pkg::OP_END, 8'hFF);
		add_item(wgm_pkg::OP_CLEAR, 8'hA5);
		add_item(wgm_pkg::OP_APPEND, wgm_pkg::CH_STAR); // match-all form
		add_item(wgm_pkg::OP_APPEND, wgm_pkg::CH_DOT);
		add_item(wgm_pkg::OP_APPEND, wgm_pkg::CH_STAR);
		add_item(wgm_pkg::OP_SUBJECT, "x");
		add_item(wgm_pkg::OP_END, 8'h5A);
		add_item(wgm_pkg::OP_CLEAR, 8'h00);
		add_item(wgm_pkg::OP_APPEND, wgm_pkg::CH_ANY);  // '?' with nothing left in subject
		add_item(wgm_pkg::OP_END, 8'h00);
		add_item(wgm_pkg::OP_CLEAR, 8'h00);
		add_item(wgm_pkg::OP_APPEND, "a");
		add_item(wgm_pkg::OP_APPEND, wgm_pkg::CH_STAR); // double star
		add_item(wgm_pkg::OP_APPEND, wgm_pkg::CH_STAR);
		add_item(wgm_pkg::OP_APPEND, "Z");
		add_item(wgm_pkg::OP_SUBJECT, "A");
		add_item(wgm_pkg::OP_SUBJECT, "z");
		add_item(wgm_pkg::OP_END, 8'h00);
		add_item(wgm_pkg::OP_SUBJECT, "q");
		add_item(wgm_pkg::OP_APPEND, wgm_pkg::CH_STAR); // pattern change mid-subject
		add_item(wgm_pkg::OP_SUBJECT, "a");
		add_item(wgm_pkg::OP_END, 8'h00);
		add_drain();

		while (item_count < ITEM_GOAL) begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 6)) begin
					add_item(wgm_pkg::op_t'($urandom_range(0, 3)),
						8'($urandom_range(0, 255)));
				end
			end else begin
				add_item(wgm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
				gen_pat.delete();
				r = $urandom_range(0, 99);
				if (r < 5) len = 0;
				else if (r < 80) len = $urandom_range(1, 8);
				else if (r < 94) len = $urandom_range(9, PMAX);
				else len = $urandom_range(PMAX + 1, PMAX + 8);
				if ($urandom_range(0, 15) == 0) begin
					gen_pat = '{wgm_pkg::CH_STAR, wgm_pkg::CH_DOT, wgm_pkg::CH_STAR};
				end else begin
					repeat (len) gen_pat.push_back(pick_pat_byte());
				end
				foreach (gen_pat[k]) add_item(wgm_pkg::OP_APPEND, gen_pat[k]);
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 11) == 0) begin
						add_item(wgm_pkg::OP_SUBJECT, subj_byte());
						b = pick_pat_byte();
						gen_pat.push_back(b);
						add_item(wgm_pkg::OP_APPEND, b);
					end
					add_subject();
				end
				if ($urandom_range(0, 19) == 0) begin
					add_drain();
				end
			end
		end
	endtask

	// sender: bursts of random length separated by random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			op <= wgm_pkg::OP_CLEAR;
			char_code <= 8'h00;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (item_valid && !item_stall) begin
				glob_predict(wgm_pkg::op_t'(op), char_code);
			end
			if (item_valid && item_stall) begin
				// transaction held until accepted
			end else if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (glob_items.size() == 0) begin
				item_valid <= 1'b0;
			end else if (glob_items[0].drain) begin
				item_valid <= 1'b0;
				if (verdicts_due.size() == 0) begin
					void'(glob_items.pop_front());
				end
			end else begin
				item_valid <= 1'b1;
				op <= glob_items[0].opc;
				char_code <= glob_items[0].ch;
				void'(glob_items.pop_front());
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// receiver: stall runs and free runs of random length
	int       stall_left = 0;
	int       free_left = 0;
	logic     stall_nxt;
	verdict_t got_due;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
			free_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (verdicts_due.size() == 0) begin
					$error("unexpected result: matched %0b pattern_overflow %0b",
						matched, pattern_overflow);
					errors++;
				end else begin
					got_due = verdicts_due.pop_front();
					if (matched !== got_due.matched) begin
						$error("matched: expected %0b, got %0b", got_due.matched, matched);
						errors++;
					end
					if (pattern_overflow !== got_due.overflow) begin
						$error("pattern_overflow: expected %0b, got %0b",
							got_due.overflow, pattern_overflow);
						errors++;
					end
				end
			end
			if (stall_left == 0 && free_left == 0) begin
				stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				free_left = $urandom_range(1, 20);
			end
			if (stall_left > 0) begin
				stall_left--;
				stall_nxt = 1'b1;
			end else begin
				free_left--;
				stall_nxt = 1'b0;
			end
			result_stall <= stall_nxt;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("FAIL wildcard_glob_matcher_core");
			$finish;
		end
	end

	initial begin
		build_stimulus();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (glob_items.size() != 0 || item_valid || verdicts_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (errors == 0 && verdicts_due.size() == 0) begin
			$display("PASS wildcard_glob_matcher_core");
		end else begin
			$display("FAIL wildcard_glob_matcher_core");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/wgm_pkg.sv
hdl/wgm_cell.sv
hdl/wildcard_glob_matcher_core.sv
test/tb_wildcard_glob_matcher_core.sv
